// ===== design/smbrw_pkg.sv =====
// Shared types and constants for the SMBus read-word master.
// No dependencies; every design file refers to it by scoped names.

package smbrw_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned WORD_W  = 16;
	localparam int unsigned RETRY_W = 4;
	localparam int unsigned BITC_W  = 4;
	localparam int unsigned BIDX_W  = 3;
	localparam int unsigned CIDX_W  = 2;
	localparam int unsigned IN_TW   = 8;
	localparam int unsigned OUT_TW  = 32;

	localparam logic [BYTE_W-1:0]  WR_ADDR_RST = 8'h00;
	localparam logic [BYTE_W-1:0]  CMD_RST     = 8'h07;
	localparam logic [BYTE_W-1:0]  RD_ADDR_RST = 8'h01;
	localparam logic [RETRY_W-1:0] RETRY_RST   = 4'd10;

	localparam logic ACK_LEVEL  = 1'b0;
	localparam logic NACK_LEVEL = 1'b1;

	localparam logic [BIDX_W-1:0] BIDX_WADDR = 3'd0;
	localparam logic [BIDX_W-1:0] BIDX_CMD   = 3'd1;
	localparam logic [BIDX_W-1:0] BIDX_RADDR = 3'd2;
	localparam logic [BIDX_W-1:0] BIDX_LOW   = 3'd3;
	localparam logic [BIDX_W-1:0] BIDX_HIGH  = 3'd4;
	localparam logic [BIDX_W-1:0] BIDX_PEC   = 3'd5;

	typedef enum logic [CIDX_W-1:0] {
		REG_WR_ADDR = 2'd0,
		REG_CMD     = 2'd1,
		REG_RD_ADDR = 2'd2,
		REG_RETRY   = 2'd3
	} reg_idx_t;

	typedef enum logic [4:0] {
		PH_IDLE   = 5'd0,
		PH_START1 = 5'd1,
		PH_START2 = 5'd2,
		PH_START3 = 5'd3,
		PH_START4 = 5'd4,
		PH_SEND1  = 5'd5,
		PH_SEND2  = 5'd6,
		PH_SEND3  = 5'd7,
		PH_ACKIN1 = 5'd8,
		PH_ACKIN2 = 5'd9,
		PH_ACKIN3 = 5'd10,
		PH_STOPN1 = 5'd11,
		PH_STOPN2 = 5'd12,
		PH_STOPN3 = 5'd13,
		PH_STOPN4 = 5'd14,
		PH_RECV1  = 5'd15,
		PH_RECV2  = 5'd16,
		PH_RECV3  = 5'd17,
		PH_AOUT1  = 5'd18,
		PH_AOUT2  = 5'd19,
		PH_AOUT3  = 5'd20,
		PH_STOPF1 = 5'd21,
		PH_STOPF2 = 5'd22,
		PH_STOPF3 = 5'd23,
		PH_STOPF4 = 5'd24
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  wr_addr;
		logic [BYTE_W-1:0]  cmd;
		logic [BYTE_W-1:0]  rd_addr;
		logic [RETRY_W-1:0] retry_limit;
	} cfg_t;

	typedef struct packed {
		logic              error_code;
		logic [BYTE_W-1:0] pec_value;
		logic [WORD_W-1:0] word_value;
		logic              done_res;
		logic              busy_res;
		logic              sda_level;
		logic              scl_level;
	} res_t;

endpackage

// ===== design/smbrw_cfg.sv =====
// Configuration register file for the SMBus read-word master.
// Depends on smbrw_pkg for register indexes and reset values.

module smbrw_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [smbrw_pkg::CIDX_W-1:0]        cfg_index,
	input  logic [smbrw_pkg::BYTE_W-1:0]        cfg_wdata,
	output smbrw_pkg::cfg_t                     cfg
);

	smbrw_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wr_addr     <= smbrw_pkg::WR_ADDR_RST;
			cfg_q.cmd         <= smbrw_pkg::CMD_RST;
			cfg_q.rd_addr     <= smbrw_pkg::RD_ADDR_RST;
			cfg_q.retry_limit <= smbrw_pkg::RETRY_RST;
		end else if (cfg_we) begin
			case (smbrw_pkg::reg_idx_t'(cfg_index))
				smbrw_pkg::REG_WR_ADDR: cfg_q.wr_addr <= cfg_wdata;
				smbrw_pkg::REG_CMD:     cfg_q.cmd     <= cfg_wdata;
				smbrw_pkg::REG_RD_ADDR: cfg_q.rd_addr <= cfg_wdata;
				smbrw_pkg::REG_RETRY:
					cfg_q.retry_limit <= cfg_wdata[smbrw_pkg::RETRY_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/smbrw_seq.sv =====
// Pin-phase sequencer: state registers and next-phase logic for one tick.
// Depends on smbrw_pkg for the phase enum, config and result structs.

module smbrw_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                start_request,
	input  logic                sda_in,
	input  smbrw_pkg::cfg_t     cfg,
	output smbrw_pkg::res_t     res
);

	smbrw_pkg::phase_t                  phase_q, phase_n;
	logic [smbrw_pkg::BITC_W-1:0]       bitc_q, bitc_n;
	logic [smbrw_pkg::BYTE_W-1:0]       shift_q, shift_n;
	logic [smbrw_pkg::BIDX_W-1:0]       bidx_q, bidx_n;
	logic [smbrw_pkg::RETRY_W-1:0]      retries_q, retries_n;
	logic [smbrw_pkg::BYTE_W-1:0]       low_q, low_n, high_q, high_n, pec_q, pec_n;
	logic                               nack_q, nack_n;
	logic                               scl_q, scl_n, sda_q, sda_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= smbrw_pkg::PH_IDLE;
			bitc_q    <= '0;
			shift_q   <= '0;
			bidx_q    <= '0;
			retries_q <= '0;
			low_q     <= '0;
			high_q    <= '0;
			pec_q     <= '0;
			nack_q    <= 1'b0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
		end else if (step) begin
			phase_q   <= phase_n;
			bitc_q    <= bitc_n;
			shift_q   <= shift_n;
			bidx_q    <= bidx_n;
			retries_q <= retries_n;
			low_q     <= low_n;
			high_q    <= high_n;
			pec_q     <= pec_n;
			nack_q    <= nack_n;
			scl_q     <= scl_n;
			sda_q     <= sda_n;
		end
	end

	always_comb begin
		logic                          idle_out;
		logic                          done;
		logic                          adv;
		logic [smbrw_pkg::BITC_W-1:0]  bitc_inc;
		smbrw_pkg::phase_t             ph;

		idle_out  = 1'b0;
		done      = 1'b0;
		adv       = 1'b0;
		ph        = phase_q;
		phase_n   = phase_q;
		bitc_n    = bitc_q;
		shift_n   = shift_q;
		bidx_n    = bidx_q;
		retries_n = retries_q;
		low_n     = low_q;
		high_n    = high_q;
		pec_n     = pec_q;
		nack_n    = nack_q;
		scl_n     = scl_q;
		sda_n     = sda_q;
		bitc_inc  = bitc_q + smbrw_pkg::BITC_W'(1);

		if (phase_q == smbrw_pkg::PH_IDLE) begin
			if (start_request) begin
				bidx_n    = smbrw_pkg::BIDX_WADDR;
				nack_n    = 1'b0;
				retries_n = cfg.retry_limit;
				ph        = smbrw_pkg::PH_START1;
			end else begin
				idle_out = 1'b1;
			end
		end

		if (!idle_out) begin
			case (ph)
				smbrw_pkg::PH_START1: begin sda_n = 1'b1; phase_n = smbrw_pkg::PH_START2; end
				smbrw_pkg::PH_START2: begin scl_n = 1'b1; phase_n = smbrw_pkg::PH_START3; end
				smbrw_pkg::PH_START3: begin sda_n = 1'b0; phase_n = smbrw_pkg::PH_START4; end
				smbrw_pkg::PH_START4: begin
					scl_n = 1'b0;
					if (bidx_n == smbrw_pkg::BIDX_WADDR)    shift_n = cfg.wr_addr;
					else if (bidx_n == smbrw_pkg::BIDX_CMD) shift_n = cfg.cmd;
					else                                    shift_n = cfg.rd_addr;
					bitc_n  = '0;
					phase_n = smbrw_pkg::PH_SEND1;
				end
				smbrw_pkg::PH_SEND1: begin
					sda_n   = shift_q[smbrw_pkg::BYTE_W-1];
					phase_n = smbrw_pkg::PH_SEND2;
				end
				smbrw_pkg::PH_SEND2: begin scl_n = 1'b1; phase_n = smbrw_pkg::PH_SEND3; end
				smbrw_pkg::PH_SEND3: begin
					scl_n   = 1'b0;
					shift_n = {shift_q[smbrw_pkg::BYTE_W-2:0], 1'b0};
					bitc_n  = bitc_inc;
					phase_n = bitc_inc[smbrw_pkg::BITC_W-1] ? smbrw_pkg::PH_ACKIN1
					                                        : smbrw_pkg::PH_SEND1;
				end
				smbrw_pkg::PH_ACKIN1: begin sda_n = 1'b1; phase_n = smbrw_pkg::PH_ACKIN2; end
				smbrw_pkg::PH_ACKIN2: begin scl_n = 1'b1; phase_n = smbrw_pkg::PH_ACKIN3; end
				smbrw_pkg::PH_ACKIN3: begin
					scl_n = 1'b0;
					if (sda_in == smbrw_pkg::NACK_LEVEL) phase_n = smbrw_pkg::PH_STOPN1;
					else                                 adv     = 1'b1;
				end
				smbrw_pkg::PH_STOPN1: begin scl_n = 1'b0; phase_n = smbrw_pkg::PH_STOPN2; end
				smbrw_pkg::PH_STOPN2: begin sda_n = 1'b0; phase_n = smbrw_pkg::PH_STOPN3; end
				smbrw_pkg::PH_STOPN3: begin scl_n = 1'b1; phase_n = smbrw_pkg::PH_STOPN4; end
				smbrw_pkg::PH_STOPN4: begin
					sda_n = 1'b1;
					if (retries_q != '0) begin
						retries_n = retries_q - smbrw_pkg::RETRY_W'(1);
						phase_n   = smbrw_pkg::PH_START1;
					end else begin
						nack_n = 1'b1;
						adv    = 1'b1;
					end
				end
				smbrw_pkg::PH_RECV1: begin sda_n = 1'b1; phase_n = smbrw_pkg::PH_RECV2; end
				smbrw_pkg::PH_RECV2: begin scl_n = 1'b1; phase_n = smbrw_pkg::PH_RECV3; end
				smbrw_pkg::PH_RECV3: begin
					scl_n   = 1'b0;
					shift_n = {shift_q[smbrw_pkg::BYTE_W-2:0], sda_in};
					bitc_n  = bitc_inc;
					if (bitc_inc[smbrw_pkg::BITC_W-1]) begin
						if (bidx_q == smbrw_pkg::BIDX_LOW)       low_n  = shift_n;
						else if (bidx_q == smbrw_pkg::BIDX_HIGH) high_n = shift_n;
						else                                     pec_n  = shift_n;
						phase_n = smbrw_pkg::PH_AOUT1;
					end else begin
						phase_n = smbrw_pkg::PH_RECV1;
					end
				end
				smbrw_pkg::PH_AOUT1: begin
					sda_n   = (bidx_q >= smbrw_pkg::BIDX_PEC) ? smbrw_pkg::NACK_LEVEL
					                                          : smbrw_pkg::ACK_LEVEL;
					phase_n = smbrw_pkg::PH_AOUT2;
				end
				smbrw_pkg::PH_AOUT2: begin scl_n = 1'b1; phase_n = smbrw_pkg::PH_AOUT3; end
				smbrw_pkg::PH_AOUT3: begin
					scl_n = 1'b0;
					if (bidx_q >= smbrw_pkg::BIDX_PEC) begin
						phase_n = smbrw_pkg::PH_STOPF1;
					end else begin
						bidx_n  = bidx_q + smbrw_pkg::BIDX_W'(1);
						bitc_n  = '0;
						shift_n = '0;
						phase_n = smbrw_pkg::PH_RECV1;
					end
				end
				smbrw_pkg::PH_STOPF1: begin scl_n = 1'b0; phase_n = smbrw_pkg::PH_STOPF2; end
				smbrw_pkg::PH_STOPF2: begin sda_n = 1'b0; phase_n = smbrw_pkg::PH_STOPF3; end
				smbrw_pkg::PH_STOPF3: begin scl_n = 1'b1; phase_n = smbrw_pkg::PH_STOPF4; end
				smbrw_pkg::PH_STOPF4: begin
					sda_n   = 1'b1;
					done    = 1'b1;
					phase_n = smbrw_pkg::PH_IDLE;
				end
				default: phase_n = smbrw_pkg::PH_IDLE;
			endcase

			// advance to the next written byte or into the read phase
			if (adv) begin
				if (bidx_q == smbrw_pkg::BIDX_WADDR) begin
					bidx_n    = smbrw_pkg::BIDX_CMD;
					retries_n = cfg.retry_limit;
					shift_n   = cfg.cmd;
					bitc_n    = '0;
					phase_n   = smbrw_pkg::PH_SEND1;
				end else if (bidx_q == smbrw_pkg::BIDX_CMD) begin
					bidx_n    = smbrw_pkg::BIDX_RADDR;
					retries_n = cfg.retry_limit;
					phase_n   = smbrw_pkg::PH_START1;
				end else begin
					bidx_n  = smbrw_pkg::BIDX_LOW;
					bitc_n  = '0;
					shift_n = '0;
					phase_n = smbrw_pkg::PH_RECV1;
				end
			end
		end

		res.scl_level  = idle_out ? 1'b1 : scl_n;
		res.sda_level  = idle_out ? 1'b1 : sda_n;
		res.busy_res   = !idle_out;
		res.done_res   = done;
		res.word_value = done ? {high_n, low_n} : '0;
		res.pec_value  = done ? pec_n : '0;
		res.error_code = done & nack_n;
	end

endmodule

// ===== design/smbrw_out.sv =====
// Result register between the sequencer and the output stream.
// Depends on smbrw_pkg for the result struct.

module smbrw_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  smbrw_pkg::res_t     res,
	input  logic                out_ready,
	output logic                out_valid,
	output logic                can_load,
	output smbrw_pkg::res_t     res_q
);

	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign can_load  = !valid_q || out_ready;

endmodule

// ===== design/smbus_read_word_master.sv =====
// Top level of the SMBus read-word master: config registers, pin-phase
// sequencer and result register. Depends on smbrw_pkg, smbrw_cfg,
// smbrw_seq and smbrw_out.
//
// Usage: every input transaction on s_axis is one pin phase tick and
// carries start_request and the sampled SDA level. Each tick yields one
// output transaction on m_axis with the SCL/SDA drive levels and busy flag;
// tlast marks the final phase of a read-word, whose transaction also
// carries the word, the PEC byte and the error flag.
// Output: a tick's result is registered, valid in the cycle after acceptance.
// Throughput: one tick per cycle while m_axis is not stalled; the
// sequencer state and the result register both update in the accepting cycle.
// Stall: s_axis_tready is high while the result register is empty or
// being drained, so a stalled m_axis holds one result and blocks input.
// Reset: arst_n clears the sequencer to idle with both lines released,
// empties the result register and loads the register defaults.
// Config: write cfg_wdata to register cfg_index while cfg_we is high,
// only while no transaction is in progress.

module smbus_read_word_master (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// start_request, sda_in, zero padding
	input  logic [smbrw_pkg::IN_TW-1:0]         s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// scl_level, sda_level, busy_res, word_value, pec_value, error_code, zero padding
	output logic [smbrw_pkg::OUT_TW-1:0]        m_axis_tdata,
	output logic                                m_axis_tlast,
	input  logic                                cfg_we,
	input  logic [smbrw_pkg::CIDX_W-1:0]        cfg_index,
	input  logic [smbrw_pkg::BYTE_W-1:0]        cfg_wdata
);

	smbrw_pkg::cfg_t cfg;
	smbrw_pkg::res_t res, res_q;
	logic            accept;
	logic            can_load;

	assign s_axis_tready = can_load;
	assign accept        = s_axis_tvalid && can_load;

	smbrw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	smbrw_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (accept),
		.start_request (s_axis_tdata[0]),
		.sda_in        (s_axis_tdata[1]),
		.cfg           (cfg),
		.res           (res)
	);

	smbrw_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.res       (res),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.can_load  (can_load),
		.res_q     (res_q)
	);

	assign m_axis_tdata = {4'b0, res_q.error_code, res_q.pec_value, res_q.word_value,
	                       res_q.busy_res, res_q.sda_level, res_q.scl_level};
	assign m_axis_tlast = res_q.done_res;

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted tick produced no result");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[2] && m_axis_tdata[1:0] == 2'b11)
		else $error("final phase without busy or with a line held low");

	a_idle_released: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[1:0] == 2'b11 && !m_axis_tlast)
		else $error("idle result drives a line low");

	a_error_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[27] |-> m_axis_tlast)
		else $error("error flag outside the final phase");

endmodule
